// ----- hw/rtl/box_filter_3x3_mean_top_defines.svh -----
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_top_defines
// assertion macros shared by the box filter modules
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_MEAN_TOP_DEFINES_SVH
`define BOX_FILTER_3X3_MEAN_TOP_DEFINES_SVH

// same-cycle implication
`define BF3M_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BF3M_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bf3m_pkg.sv -----
// ----------------------------------------------------------------------------
// bf3m_pkg
// shared types and constants of the 3x3 box filter
// ----------------------------------------------------------------------------
package bf3m_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 11;
	localparam int POS_W       = 10;
	localparam int SUM_W       = 12;
	localparam int PROD_W      = 24;
	localparam int RECIP_SHIFT = 15;
	localparam int REG_IDX_W   = 1;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = 3;
	localparam int FIFO_CNT_W  = 4;

	// ceil(2^15 / 9), exact floor division for sums up to 9 * 255
	localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd5;
	localparam logic [CFG_W-1:0] SIZE_MIN   = 11'd3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LINE_LENGTH = 1'b0,
		REG_LINE_COUNT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} pos_tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] mean;
		pos_tag_t         tag;
	} result_t;

endpackage

// ----- hw/rtl/bf3m_line_store.sv -----
// ----------------------------------------------------------------------------
// bf3m_line_store
// one line of pixels, synchronous memory with one write and one read port
// ----------------------------------------------------------------------------
module bf3m_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [bf3m_pkg::PIX_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [bf3m_pkg::PIX_W-1:0] rdata
);
	import bf3m_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bf3m_window.sv -----
// ----------------------------------------------------------------------------
// bf3m_window
// 3x3 window columns, nine-pixel sum and reciprocal divide by nine
// ----------------------------------------------------------------------------
module bf3m_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       has_result,
	input  bf3m_pkg::pos_tag_t         tag,
	input  logic [bf3m_pkg::PIX_W-1:0] top,
	input  logic [bf3m_pkg::PIX_W-1:0] mid,
	input  logic [bf3m_pkg::PIX_W-1:0] px,
	output logic                       res_valid,
	output bf3m_pkg::result_t          res,
	output logic [1:0]                 inflight
);
	import bf3m_pkg::*;

	logic [PIX_W-1:0]  win_q [6];
	logic [SUM_W-1:0]  sum;
	logic              valid_s2;
	logic [SUM_W-1:0]  sum_s2;
	pos_tag_t          tag_s2;
	logic              valid_s3;
	logic [PROD_W-1:0] prod_s3;
	pos_tag_t          tag_s3;

	always_comb begin
		sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px);
		for (int k = 0; k < 6; k++) begin
			sum = sum + SUM_W'(win_q[k]);
		end
	end

	// column c-2 in entries 0..2, column c-1 in entries 3..5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else if (step) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= step && has_result;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sum_s2 <= sum;
			tag_s2 <= tag;
		end
		prod_s3 <= PROD_W'(sum_s2) * PROD_W'(RECIP_NINE);
		tag_s3  <= tag_s2;
	end

	assign res_valid = valid_s3;
	assign res.mean  = prod_s3[RECIP_SHIFT +: PIX_W];
	assign res.tag   = tag_s3;
	assign inflight  = {1'b0, valid_s2} + {1'b0, valid_s3};

endmodule

// ----- hw/rtl/bf3m_out_fifo.sv -----
// ----------------------------------------------------------------------------
// bf3m_out_fifo
// result queue in front of the output channel
// ----------------------------------------------------------------------------
`include "box_filter_3x3_mean_top_defines.svh"

module bf3m_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  bf3m_pkg::result_t               push_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bf3m_pkg::result_t               head,
	output logic [bf3m_pkg::FIFO_CNT_W-1:0] count
);
	import bf3m_pkg::*;

	result_t                 data_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = data_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`BF3M_ASSERT_IMP(a_fifo_no_overflow, clk, arst_n, push && !pop, count_q < FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
	`BF3M_ASSERT_NXT(a_fifo_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + FIFO_CNT_W'(1), "queue count lost a push")

endmodule

// ----- hw/rtl/box_filter_3x3_mean_top.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_top
// 3x3 mean filter over a raster-order 8-bit pixel stream
// ----------------------------------------------------------------------------
// pixels enter on in_valid/in_ready/pixel, one item per clock when the
// output side keeps up; each item reads two line stores at its column
// the cycle it is accepted and writes them back in the following cycle
// an interior centre pixel gives one result on out_valid/out_ready with
// mean_value, out_row, out_col and frame_last; border pixels give none
// the pixel that completes a neighbourhood passes the read stage (s1),
// the sum register (s2) and the product register (s3) before its result
// enters the output queue; sustained rate with a ready receiver is 1 pixel per cycle
// an 8-entry result queue takes the results; in_ready drops once queue
// entries plus items in flight reach 8, so a stalled receiver holds the
// input back without losing results
// cfg_we/cfg_index/cfg_data set line_length and line_count (both clamped
// to 3..max); write them only while the block is idle
// reset: sizes return to 5x5, position and window clear, queue empties;
// line store contents are undefined until written, no clearing pass
// ----------------------------------------------------------------------------
`include "box_filter_3x3_mean_top_defines.svh"

module box_filter_3x3_mean_top #(
	parameter int MAX_LINE_LENGTH = 1024,
	parameter int MAX_LINE_COUNT  = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bf3m_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bf3m_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bf3m_pkg::PIX_W-1:0]     pixel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bf3m_pkg::PIX_W-1:0]     mean_value,
	output logic [bf3m_pkg::POS_W-1:0]     out_row,
	output logic [bf3m_pkg::POS_W-1:0]     out_col,
	output logic                           frame_last
);
	import bf3m_pkg::*;

	localparam int COL_W = $clog2(MAX_LINE_LENGTH);
	localparam int ROW_W = $clog2(MAX_LINE_COUNT);
	localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);
	localparam int CNT_W = $clog2(MAX_LINE_COUNT + 1);
	localparam int LW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam int KW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int CXW   = (COL_W > POS_W) ? COL_W : POS_W;
	localparam int RXW   = (ROW_W > POS_W) ? ROW_W : POS_W;

	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LINE_LENGTH);
	localparam logic [KW-1:0] CNT_MAX = KW'(MAX_LINE_COUNT);

	logic [CFG_W-1:0]      line_length_q;
	logic [CFG_W-1:0]      line_count_q;
	logic [LW-1:0]         len_use;
	logic [KW-1:0]         cnt_use;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [LW-1:0]         col_ext;
	logic [LW-1:0]         col_inc;
	logic [KW-1:0]         row_ext;
	logic [KW-1:0]         row_inc;
	logic                  col_wrap;
	logic                  row_wrap;
	logic                  in_accept;
	logic                  has_result;
	pos_tag_t              tag;
	logic [CXW-1:0]        col_m1;
	logic [RXW-1:0]        row_m1;

	logic                  s1_valid;
	logic [PIX_W-1:0]      px_s1;
	logic [COL_W-1:0]      addr_s1;
	logic                  res_s1;
	pos_tag_t              tag_s1;

	logic [PIX_W-1:0]      top_rd;
	logic [PIX_W-1:0]      mid_rd;
	logic                  res_valid;
	result_t               res;
	logic [1:0]            win_inflight;
	result_t               head;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W-1:0] occupancy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= SIZE_RESET;
			line_count_q  <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data;
				REG_LINE_COUNT:  line_count_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	// sizes in use, clamped to 3..max
	always_comb begin
		if (line_length_q < SIZE_MIN) begin
			len_use = LW'(SIZE_MIN);
		end else if (LW'(line_length_q) > LEN_MAX) begin
			len_use = LEN_MAX;
		end else begin
			len_use = LW'(line_length_q);
		end
		if (line_count_q < SIZE_MIN) begin
			cnt_use = KW'(SIZE_MIN);
		end else if (KW'(line_count_q) > CNT_MAX) begin
			cnt_use = CNT_MAX;
		end else begin
			cnt_use = KW'(line_count_q);
		end
	end

	assign occupancy = fifo_count + FIFO_CNT_W'(s1_valid) + FIFO_CNT_W'(win_inflight);
	assign in_ready  = (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
	assign in_accept = in_valid && in_ready;

	assign col_ext  = LW'(col_q);
	assign col_inc  = col_ext + LW'(1);
	assign col_wrap = (col_inc >= len_use);
	assign row_ext  = KW'(row_q);
	assign row_inc  = row_ext + KW'(1);
	assign row_wrap = (row_inc >= cnt_use);

	assign has_result = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
	assign col_m1     = CXW'(col_q) - CXW'(1);
	assign row_m1     = RXW'(row_q) - RXW'(1);
	assign tag.row    = row_m1[POS_W-1:0];
	assign tag.col    = col_m1[POS_W-1:0];
	assign tag.last   = (row_ext == cnt_use - KW'(1)) && (col_ext == len_use - LW'(1));

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// read stage: line stores answer the cycle after acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_s1   <= pixel;
			addr_s1 <= col_q;
			res_s1  <= has_result;
			tag_s1  <= tag;
		end
	end

	// write-back: upper takes the old middle, middle takes the new pixel
	bf3m_line_store #(
		.DEPTH (MAX_LINE_LENGTH),
		.AW    (COL_W)
	) u_store_upper (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (addr_s1),
		.wdata (mid_rd),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (top_rd)
	);

	bf3m_line_store #(
		.DEPTH (MAX_LINE_LENGTH),
		.AW    (COL_W)
	) u_store_middle (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	bf3m_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_valid),
		.has_result (res_s1),
		.tag        (tag_s1),
		.top        (top_rd),
		.mid        (mid_rd),
		.px         (px_s1),
		.res_valid  (res_valid),
		.res        (res),
		.inflight   (win_inflight)
	);

	bf3m_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.count     (fifo_count)
	);

	assign mean_value = head.mean;
	assign out_row    = head.tag.row;
	assign out_col    = head.tag.col;
	assign frame_last = head.tag.last;

	// a new read never targets the column being written back
	`BF3M_ASSERT_IMP(a_no_rw_collision, clk, arst_n, in_accept && s1_valid, col_q != addr_s1, "line store read meets pending write")
	`BF3M_ASSERT_IMP(a_credit_bound, clk, arst_n, 1'b1, occupancy <= FIFO_CNT_W'(FIFO_DEPTH), "items in flight exceed queue space")

endmodule
